FILE: rtl/pmfd_pkg.sv
// Shared types and constants for the pressure mat fall and bed-exit detector.
// Holds item mode codes, register indexes, register widths and reset values.
// No dependencies.
package pmfd_pkg;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int TIME_BITS_DEF   = 32;

	localparam int LEVEL_W    = 12;
	localparam int CONFIRM_W  = 16;
	localparam int COOLDOWN_W = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int ARM_MS = 200;

	localparam logic [LEVEL_W-1:0]    BASELINE_RST     = 12'd0;
	localparam logic [LEVEL_W-1:0]    CLEAR_MARGIN_RST = 12'd35;
	localparam logic [LEVEL_W-1:0]    FALL_STEP_RST    = 12'd800;
	localparam logic [LEVEL_W-1:0]    FALL_SLOPE_RST   = 12'd90;
	localparam logic [LEVEL_W-1:0]    EXIT_STEP_RST    = 12'd220;
	localparam logic [LEVEL_W-1:0]    EXIT_SLOPE_RST   = 12'd70;
	localparam logic [CONFIRM_W-1:0]  FALL_CONFIRM_RST = 16'd250;
	localparam logic [COOLDOWN_W-1:0] COOLDOWN_RST     = 24'd60000;

	typedef enum logic [1:0] {
		MODE_SAMPLE     = 2'd0,
		MODE_CLEAR_FALL = 2'd1,
		MODE_RESET      = 2'd2,
		MODE_ENABLE     = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASELINE     = 3'd0,
		REG_CLEAR_MARGIN = 3'd1,
		REG_FALL_STEP    = 3'd2,
		REG_FALL_SLOPE   = 3'd3,
		REG_EXIT_STEP    = 3'd4,
		REG_EXIT_SLOPE   = 3'd5,
		REG_FALL_CONFIRM = 3'd6,
		REG_COOLDOWN     = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [LEVEL_W-1:0]    baseline;
		logic [LEVEL_W-1:0]    clear_margin;
		logic [LEVEL_W-1:0]    fall_step;
		logic [LEVEL_W-1:0]    fall_slope;
		logic [LEVEL_W-1:0]    exit_step;
		logic [LEVEL_W-1:0]    exit_slope;
		logic [CONFIRM_W-1:0]  fall_hold_ms;
		logic [COOLDOWN_W-1:0] exit_cooldown_ms;
	} cfg_regs_t;

endpackage

FILE: rtl/pmfd_cfg.sv
// Configuration register file for the detector thresholds and timers.
// Depends on pmfd_pkg for register indexes, widths and reset values.
module pmfd_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pmfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pmfd_pkg::CFG_DATA_W-1:0] cfg_data,
	output pmfd_pkg::cfg_regs_t             regs
);
	import pmfd_pkg::*;

	cfg_regs_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.baseline         <= BASELINE_RST;
			regs_q.clear_margin     <= CLEAR_MARGIN_RST;
			regs_q.fall_step        <= FALL_STEP_RST;
			regs_q.fall_slope       <= FALL_SLOPE_RST;
			regs_q.exit_step        <= EXIT_STEP_RST;
			regs_q.exit_slope       <= EXIT_SLOPE_RST;
			regs_q.fall_hold_ms     <= FALL_CONFIRM_RST;
			regs_q.exit_cooldown_ms <= COOLDOWN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_BASELINE:     regs_q.baseline         <= cfg_data[LEVEL_W-1:0];
				REG_CLEAR_MARGIN: regs_q.clear_margin     <= cfg_data[LEVEL_W-1:0];
				REG_FALL_STEP:    regs_q.fall_step        <= cfg_data[LEVEL_W-1:0];
				REG_FALL_SLOPE:   regs_q.fall_slope       <= cfg_data[LEVEL_W-1:0];
				REG_EXIT_STEP:    regs_q.exit_step        <= cfg_data[LEVEL_W-1:0];
				REG_EXIT_SLOPE:   regs_q.exit_slope       <= cfg_data[LEVEL_W-1:0];
				REG_FALL_CONFIRM: regs_q.fall_hold_ms     <= cfg_data[CONFIRM_W-1:0];
				REG_COOLDOWN:     regs_q.exit_cooldown_ms <= cfg_data[COOLDOWN_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/pmfd_core.sv
// Detector state and single-pass item evaluation: slope, clear-mat timer,
// fall confirmation and bed-exit arming with cooldown. Depends on pmfd_pkg.
module pmfd_core #(
	parameter int SAMPLE_BITS = pmfd_pkg::SAMPLE_BITS_DEF,
	parameter int TIME_BITS   = pmfd_pkg::TIME_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [1:0]             mode,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [TIME_BITS-1:0]   now_ms,
	input  logic                   enable,
	input  pmfd_pkg::cfg_regs_t    regs,
	output logic                   mat_clear,
	output logic                   bed_exit,
	output logic                   fall,
	output logic [SAMPLE_BITS:0]   slope,
	output logic                   fall_pending
);
	import pmfd_pkg::*;

	localparam int CMP_W = (SAMPLE_BITS > LEVEL_W ? SAMPLE_BITS : LEVEL_W) + 1;
	localparam int SL_W  = SAMPLE_BITS + 1;

	logic [SAMPLE_BITS-1:0] last_sample_q, last_sample_d;
	logic signed [SL_W-1:0] last_slope_q, last_slope_d;
	logic                   last_clear_q, last_clear_d;
	logic [TIME_BITS-1:0]   clear_start_q, clear_start_d;
	logic                   clear_valid_q, clear_valid_d;
	logic                   armed_q, armed_d;
	logic [TIME_BITS-1:0]   cooldown_q, cooldown_d;
	logic                   fall_wait_q, fall_wait_d;
	logic [TIME_BITS-1:0]   fall_start_q, fall_start_d;
	logic                   fall_flag_q, fall_flag_d;
	logic                   enabled_q, enabled_d;
	logic                   evt;

	logic signed [SL_W-1:0]  slope_n;
	logic signed [CMP_W:0]   slope_x, fall_slope_x, exit_slope_x;
	logic [CMP_W-1:0]        raw_x, clear_lvl, fall_lvl, exit_lvl;
	logic                    clr, high, fall_lvl_hit, exit_lvl_hit;
	logic [TIME_BITS-1:0]    cs_eff, clear_el, fall_el, cd_el, cd_next;
	logic [TIME_BITS+23:0]   cd_sum;
	logic [TIME_BITS+15:0]   fall_el_x, confirm_x;
	logic                    armed_mid, fw_mid, ff_mid;

	always_comb begin
		slope_n      = $signed({1'b0, sample}) - $signed({1'b0, last_sample_q});
		slope_x      = (CMP_W+1)'(slope_n);
		fall_slope_x = $signed({1'b0, CMP_W'(regs.fall_slope)});
		exit_slope_x = $signed({1'b0, CMP_W'(regs.exit_slope)});
		raw_x        = CMP_W'(sample);
		clear_lvl    = CMP_W'(regs.baseline) + CMP_W'(regs.clear_margin);
		fall_lvl     = CMP_W'(regs.baseline) + CMP_W'(regs.fall_step);
		exit_lvl     = CMP_W'(regs.baseline) + CMP_W'(regs.exit_step);
		clr          = raw_x <= clear_lvl;
		fall_lvl_hit = raw_x >= fall_lvl;
		exit_lvl_hit = raw_x >= exit_lvl;
		high         = !clr && fall_lvl_hit;
		cs_eff       = clear_valid_q ? clear_start_q : now_ms;
		clear_el     = now_ms - cs_eff;
		fall_el      = now_ms - fall_start_q;
		fall_el_x    = {16'd0, fall_el};
		confirm_x    = {TIME_BITS'(0), regs.fall_hold_ms};
		cd_el        = now_ms - cooldown_q;
		cd_sum       = {24'd0, now_ms} + {TIME_BITS'(0), regs.exit_cooldown_ms};
		cd_next      = cd_sum[TIME_BITS-1:0];
	end

	always_comb begin
		last_sample_d = last_sample_q;
		last_slope_d  = last_slope_q;
		last_clear_d  = last_clear_q;
		clear_start_d = clear_start_q;
		clear_valid_d = clear_valid_q;
		armed_d       = armed_q;
		cooldown_d    = cooldown_q;
		fall_wait_d   = fall_wait_q;
		fall_start_d  = fall_start_q;
		fall_flag_d   = fall_flag_q;
		enabled_d     = enabled_q;
		evt           = 1'b0;
		armed_mid     = armed_q;
		fw_mid        = fall_wait_q;
		ff_mid        = fall_flag_q;
		case (mode_t'(mode))
			MODE_SAMPLE: begin
				last_slope_d  = slope_n;
				last_sample_d = sample;
				last_clear_d  = clr;
				if (clr) begin
					clear_start_d = cs_eff;
					clear_valid_d = 1'b1;
					if (clear_el >= TIME_BITS'(ARM_MS))
						armed_mid = 1'b1;
				end else begin
					clear_start_d = '0;
					clear_valid_d = 1'b0;
				end
				if (!fall_wait_q) begin
					if (high && slope_x >= fall_slope_x) begin
						fw_mid       = 1'b1;
						fall_start_d = now_ms;
					end
				end else if (high) begin
					if (fall_el_x >= confirm_x) begin
						ff_mid       = 1'b1;
						fw_mid       = 1'b0;
						fall_start_d = '0;
					end
				end else begin
					fw_mid       = 1'b0;
					fall_start_d = '0;
				end
				if (!ff_mid && enabled_q && armed_mid && !cd_el[TIME_BITS-1] && !clr &&
						exit_lvl_hit && slope_x >= exit_slope_x && !fall_lvl_hit) begin
					evt        = 1'b1;
					armed_mid  = 1'b0;
					cooldown_d = cd_next;
				end
				armed_d     = armed_mid;
				fall_wait_d = fw_mid;
				fall_flag_d = ff_mid;
			end
			MODE_CLEAR_FALL: begin
				fall_flag_d = 1'b0;
			end
			MODE_RESET: begin
				fall_flag_d   = 1'b0;
				armed_d       = 1'b0;
				cooldown_d    = '0;
				fall_wait_d   = 1'b0;
				fall_start_d  = '0;
				clear_start_d = '0;
				clear_valid_d = 1'b0;
				last_slope_d  = '0;
			end
			MODE_ENABLE: begin
				enabled_d = enable;
				if (!enable) begin
					armed_d       = 1'b0;
					clear_start_d = '0;
					clear_valid_d = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sample_q <= '0;
			last_slope_q  <= '0;
			last_clear_q  <= 1'b1;
			clear_start_q <= '0;
			clear_valid_q <= 1'b0;
			armed_q       <= 1'b0;
			cooldown_q    <= '0;
			fall_wait_q   <= 1'b0;
			fall_start_q  <= '0;
			fall_flag_q   <= 1'b0;
			enabled_q     <= 1'b0;
		end else if (step) begin
			last_sample_q <= last_sample_d;
			last_slope_q  <= last_slope_d;
			last_clear_q  <= last_clear_d;
			clear_start_q <= clear_start_d;
			clear_valid_q <= clear_valid_d;
			armed_q       <= armed_d;
			cooldown_q    <= cooldown_d;
			fall_wait_q   <= fall_wait_d;
			fall_start_q  <= fall_start_d;
			fall_flag_q   <= fall_flag_d;
			enabled_q     <= enabled_d;
		end
	end

	assign mat_clear    = last_clear_d;
	assign bed_exit     = evt;
	assign fall         = fall_flag_d;
	assign slope        = last_slope_d;
	assign fall_pending = fall_wait_d;

endmodule

FILE: rtl/pressure_mat_fall_and_exit_detector.sv
// Pressure mat fall and bed-exit detector, top level.
// Uses pmfd_pkg, pmfd_cfg and pmfd_core.
//
// Input words arrive on s_tvalid/s_tready; s_tuser holds the item mode
// (sample, clear fall flag, runtime reset, set enable). Every input word
// yields exactly one status word on m_tvalid/m_tready.
// The configuration channel writes one threshold or timer register per
// handshake; it is always ready and should be used only while the block
// is idle.
// Each accepted word passes through the input register and then the result
// register. Throughput: one word per cycle while the receiver is ready; the
// detector state is evaluated and updated in a single pass between the two
// registers.
// When the receiver stalls the result register holds its word and the input
// register keeps accepting until it is also full, then s_tready drops.
// Reset clears both stages and restores all registers and detector state.
module pressure_mat_fall_and_exit_detector #(
	parameter int SAMPLE_BITS = pmfd_pkg::SAMPLE_BITS_DEF,
	parameter int TIME_BITS   = pmfd_pkg::TIME_BITS_DEF,
	localparam int IN_W  = ((SAMPLE_BITS + TIME_BITS + 1 + 7) / 8) * 8,
	localparam int OUT_W = ((SAMPLE_BITS + 1 + 4 + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [IN_W-1:0]                 s_tdata,   // sample, now_ms, enable
	input  logic [1:0]                      s_tuser,   // mode
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [OUT_W-1:0]                m_tdata,   // mat_clear, bed_exit, fall,
	                                                   // slope, fall_pending
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pmfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pmfd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pmfd_pkg::*;

	localparam int RES_W = SAMPLE_BITS + 5;

	cfg_regs_t              regs;
	logic                   valid_s1;
	logic [1:0]             mode_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [TIME_BITS-1:0]   now_s1;
	logic                   enable_s1;
	logic                   advance;
	logic                   mat_clear, bed_exit, fall, fall_pending;
	logic [SAMPLE_BITS:0]   slope;
	logic                   valid_s2;
	logic [RES_W-1:0]       res_s2;

	pmfd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1   <= s_tuser;
			sample_s1 <= s_tdata[SAMPLE_BITS-1:0];
			now_s1    <= s_tdata[SAMPLE_BITS+TIME_BITS-1:SAMPLE_BITS];
			enable_s1 <= s_tdata[SAMPLE_BITS+TIME_BITS];
		end
	end

	pmfd_core #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.TIME_BITS   (TIME_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.mode         (mode_s1),
		.sample       (sample_s1),
		.now_ms       (now_s1),
		.enable       (enable_s1),
		.regs         (regs),
		.mat_clear    (mat_clear),
		.bed_exit     (bed_exit),
		.fall         (fall),
		.slope        (slope),
		.fall_pending (fall_pending)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (m_tready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= {fall_pending, slope, fall, bed_exit, mat_clear};
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = OUT_W'(res_s2);

	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_tready)
		else $error("input stalled with empty result register");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted word lost from input register");

	a_advance_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("evaluated word lost from result register");

	a_exit_not_with_fall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2[1] && res_s2[2]))
		else $error("bed-exit raised while fall flag set");

	a_exit_not_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2[1]) |-> !res_s2[0])
		else $error("bed-exit raised on a clear mat");

endmodule
